>>> hw/rtl/b64c_pkg.sv
// ---------------------------------------------------------------------------
// b64c_pkg: shared types, codes and helpers for the base64 stream codec
// Holds the job word passed from the front end to the output sequencer,
// the queue status, and the alphabet mapping functions.
// ---------------------------------------------------------------------------
package b64c_pkg;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic MODE_DATA  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='
   localparam logic [7:0] PLUS_CHAR = 8'h2B;  // '+'
   localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Up to four result words, first word in the high byte
   typedef struct packed {
      logic [31:0] words;
      logic [2:0]  count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Map a sextet to its alphabet character
   function automatic logic [7:0] b64c_enc_char(input logic [5:0] v);
      logic [7:0] c;
      begin
         if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
         end else if (v < 6'd52) begin
            c = 8'd97 + {2'b00, v} - 8'd26;
         end else if (v < 6'd62) begin
            c = 8'd48 + {2'b00, v} - 8'd52;
         end else if (v == 6'd62) begin
            c = PLUS_CHAR;
         end else begin
            c = SLASH_CHAR;
         end
         return c;
      end
   endfunction

   // Map a character to {valid, sextet}
   function automatic logic [6:0] b64c_dec_char(input logic [7:0] c);
      logic [6:0] r;
      begin
         if (c inside {[8'd65:8'd90]}) begin
            r = {1'b1, 6'(c - 8'd65)};
         end else if (c inside {[8'd97:8'd122]}) begin
            r = {1'b1, 6'(c - 8'd97 + 8'd26)};
         end else if (c inside {[8'd48:8'd57]}) begin
            r = {1'b1, 6'(c - 8'd48 + 8'd52)};
         end else if (c == PLUS_CHAR) begin
            r = {1'b1, 6'd62};
         end else if (c == SLASH_CHAR) begin
            r = {1'b1, 6'd63};
         end else begin
            r = 7'd0;
         end
         return r;
      end
   endfunction

endpackage

>>> hw/rtl/base64_stream_codec.sv
// ---------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Top level: front end, job queue and output sequencer.
// ---------------------------------------------------------------------------
// The block takes one input word per cycle whenever its two-entry job queue
// has room; a word that completes a group (or a flush) queues a job of up to
// four result words, and the output sequencer sends one result word per
// cycle while rsp_ready is high. An idle sequencer loads a finished job from
// the queue entry into its word register and then offers its first word.
// Encoding is limited by the output port, as three input words give four
// result words; decoding gives three words for four, so the input limits it.
// Writing csr_wdata (0 encode, 1 decode) clears any partial group; write it
// only while the block is idle.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_mode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import b64c_pkg::*;

   logic           push;
   logic           pop;
   job_type        push_job;
   job_type        head_job;
   queue_stat_type q_stat;

   b64c_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_mode      (req_mode),
      .q_full        (q_stat.full),
      .push          (push),
      .push_job      (push_job)
   );

   b64c_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   b64c_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .q_stat       (q_stat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   a_queue_status : assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("job pushed into a full queue");

   a_pop_data : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("job popped from an empty queue");

   a_job_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("job ended without a last word");

endmodule

>>> hw/rtl/b64c_front.sv
// ---------------------------------------------------------------------------
// b64c_front: input front end
// Accepts words, keeps the group state and the direction register, and
// pushes a finished job of result words into the queue.
// ---------------------------------------------------------------------------
module b64c_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_mode,
   input  logic             q_full,
   output logic             push,
   output b64c_pkg::job_type push_job
);
   import b64c_pkg::*;

   logic        dir_ff, dir_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] bits_ff, bits_in;

   logic        accept;
   logic [1:0]  phase_eff;
   logic [23:0] enc_bits;
   logic [23:0] dec_bits;
   logic [6:0]  dec_val;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign dec_val   = b64c_dec_char(req_data_byte);

   always_comb begin
      phase_eff = (dir_ff == DIR_ENCODE && phase_ff == 2'd3) ? 2'd0 : phase_ff;
      case (phase_eff)
         2'd0:    enc_bits = {req_data_byte, 16'h0000};
         2'd1:    enc_bits = bits_ff | {8'h00, req_data_byte, 8'h00};
         default: enc_bits = bits_ff | {16'h0000, req_data_byte};
      endcase
      case (phase_ff)
         2'd0:    dec_bits = bits_ff | {dec_val[5:0], 18'h0};
         2'd1:    dec_bits = bits_ff | {6'h00, dec_val[5:0], 12'h0};
         2'd2:    dec_bits = bits_ff | {12'h000, dec_val[5:0], 6'h0};
         default: dec_bits = bits_ff | {18'h0, dec_val[5:0]};
      endcase
   end

   always_comb begin
      dir_in         = dir_ff;
      phase_in       = phase_ff;
      bits_in        = bits_ff;
      push           = 1'b0;
      push_job.words = 32'h0;
      push_job.count = 3'd0;
      if (csr_we) begin
         dir_in   = csr_wdata;
         phase_in = 2'd0;
         bits_in  = 24'h0;
      end else if (accept) begin
         if (req_mode == MODE_FLUSH) begin
            phase_in = 2'd0;
            bits_in  = 24'h0;
            if (dir_ff == DIR_ENCODE) begin
               push_job.count = 3'd4;
               if (phase_ff == 2'd1) begin
                  push = 1'b1;
                  push_job.words = {b64c_enc_char(bits_ff[23:18]),
                                    b64c_enc_char(bits_ff[17:12]),
                                    PAD_CHAR, PAD_CHAR};
               end else if (phase_ff == 2'd2) begin
                  push = 1'b1;
                  push_job.words = {b64c_enc_char(bits_ff[23:18]),
                                    b64c_enc_char(bits_ff[17:12]),
                                    b64c_enc_char(bits_ff[11:6]), PAD_CHAR};
               end
            end else begin
               push_job.words = {bits_ff, 8'h00};
               if (phase_ff == 2'd2) begin
                  push = 1'b1;
                  push_job.count = 3'd1;
               end else if (phase_ff == 2'd3) begin
                  push = 1'b1;
                  push_job.count = 3'd2;
               end
            end
         end else if (dir_ff == DIR_ENCODE) begin
            if (phase_eff == 2'd2) begin
               push           = 1'b1;
               push_job.count = 3'd4;
               push_job.words = {b64c_enc_char(enc_bits[23:18]),
                                 b64c_enc_char(enc_bits[17:12]),
                                 b64c_enc_char(enc_bits[11:6]),
                                 b64c_enc_char(enc_bits[5:0])};
               phase_in = 2'd0;
               bits_in  = 24'h0;
            end else begin
               phase_in = phase_eff + 2'd1;
               bits_in  = enc_bits;
            end
         end else if (dec_val[6]) begin
            // skip anything outside the alphabet
            if (phase_ff == 2'd3) begin
               push           = 1'b1;
               push_job.count = 3'd3;
               push_job.words = {dec_bits, 8'h00};
               phase_in       = 2'd0;
               bits_in        = 24'h0;
            end else begin
               phase_in = phase_ff + 2'd1;
               bits_in  = dec_bits;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_ENCODE;
         phase_ff <= 2'd0;
         bits_ff  <= 24'h0;
      end else begin
         dir_ff   <= dir_in;
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

>>> hw/rtl/b64c_queue.sv
// ---------------------------------------------------------------------------
// b64c_queue: job queue
// Small first-in first-out buffer of jobs between front end and sequencer.
// ---------------------------------------------------------------------------
module b64c_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64c_pkg::job_type        push_job,
   input  logic                     pop,
   output b64c_pkg::job_type        head_job,
   output b64c_pkg::queue_stat_type stat
);
   import b64c_pkg::*;

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                     do_push, do_pop;

   assign stat.full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_job   = entry_ff[rptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      begin
         if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
         end
         return p + 1'b1;
      end
   endfunction

   always_comb begin
      wptr_in = do_push ? ptr_next(wptr_ff) : wptr_ff;
      rptr_in = do_pop ? ptr_next(rptr_ff) : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/b64c_back.sv
// ---------------------------------------------------------------------------
// b64c_back: output sequencer
// Takes one job at a time from the queue and shifts its words out, one
// word per cycle while rsp_ready is high, marking the final word of each job.
// ---------------------------------------------------------------------------
module b64c_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64c_pkg::job_type        head_job,
   input  b64c_pkg::queue_stat_type q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import b64c_pkg::*;

   logic [31:0] words_ff, words_in;
   logic [2:0]  remain_ff, remain_in;
   logic        taken;

   assign rsp_valid    = (remain_ff != 3'd0);
   assign rsp_out_byte = words_ff[31:24];
   assign rsp_last     = (remain_ff == 3'd1);
   assign taken        = rsp_valid && rsp_ready;

   always_comb begin
      words_in  = words_ff;
      remain_in = remain_ff;
      pop       = 1'b0;
      if (!q_stat.empty && (!rsp_valid || (taken && rsp_last))) begin
         // load next job when idle or as the current one drains
         pop       = 1'b1;
         words_in  = head_job.words;
         remain_in = head_job.count;
      end else if (taken) begin
         words_in  = {words_ff[23:0], 8'h00};
         remain_in = remain_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 3'd0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule
